FILE: src/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg - shared types for the sync/length/sum deframer
// State encoding and the command/status bundles that run between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam int unsigned BYTE_W = 8;

  // Value of the sync register after reset
  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;

  // Controller states: four parse phases plus the drain and empty-frame states
  typedef enum logic [2:0] {
    ST_HUNT     = 3'd0,
    ST_LEN      = 3'd1,
    ST_PAYLOAD  = 3'd2,
    ST_CHECK    = 3'd3,
    ST_DRAIN_RD = 3'd4,
    ST_DRAIN_LD = 3'd5,
    ST_EMPTY    = 3'd6
  } sld_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start_frame;    // sync seen: seed sum, clear counts
    logic load_len;       // capture the length word
    logic add_payload;    // buffer a payload word and add it to the sum
    logic clear_frame;    // checksum word consumed: clear sum and count
    logic drain_start;    // rewind the buffer read pointer
    logic rd_en;          // read the buffer at the read pointer
    logic out_load_data;  // load the output register from the buffer
    logic out_load_empty; // load the output register with the empty marker
  } sld_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_sync;        // incoming word equals the sync value
    logic len_zero;       // incoming word is zero
    logic payload_done;   // this payload word is the last of the frame
    logic check_ok;       // checksum matches and the frame fits the buffer
    logic frame_empty;    // stored length is zero
    logic drain_last;     // read pointer is at the final payload word
    logic out_free;       // output register can take a word this cycle
  } sld_sts_t;

endpackage

FILE: src/sld_ctrl.sv
// ----------------------------------------------------------------------------
// sld_ctrl - deframer controller
// Walks the frame phases on accepted input words and sequences the payload
// drain from the buffer into the output register.
// ----------------------------------------------------------------------------
module sld_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sld_pkg::sld_sts_t sts,
  output sld_pkg::sld_cmd_t cmd
);

  sld_pkg::sld_state_t state_r;
  sld_pkg::sld_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sld_pkg::ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands; in the parse states tready is high, so a valid
  // word is taken
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      sld_pkg::ST_HUNT: begin
        in_tready = 1'b1;
        if (in_tvalid && sts.is_sync) begin
          cmd.start_frame = 1'b1;
          state_nxt       = sld_pkg::ST_LEN;
        end
      end
      sld_pkg::ST_LEN: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_len = 1'b1;
          state_nxt    = sts.len_zero ? sld_pkg::ST_CHECK : sld_pkg::ST_PAYLOAD;
        end
      end
      sld_pkg::ST_PAYLOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.add_payload = 1'b1;
          if (sts.payload_done) begin
            state_nxt = sld_pkg::ST_CHECK;
          end
        end
      end
      sld_pkg::ST_CHECK: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.clear_frame = 1'b1;
          if (sts.check_ok) begin
            cmd.drain_start = 1'b1;
            state_nxt = sts.frame_empty ? sld_pkg::ST_EMPTY : sld_pkg::ST_DRAIN_RD;
          end else begin
            state_nxt = sld_pkg::ST_HUNT;
          end
        end
      end
      sld_pkg::ST_DRAIN_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = sld_pkg::ST_DRAIN_LD;
      end
      sld_pkg::ST_DRAIN_LD: begin
        if (sts.out_free) begin
          cmd.out_load_data = 1'b1;
          state_nxt = sts.drain_last ? sld_pkg::ST_HUNT : sld_pkg::ST_DRAIN_RD;
        end
      end
      sld_pkg::ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.out_load_empty = 1'b1;
          state_nxt          = sld_pkg::ST_HUNT;
        end
      end
      default: begin
        state_nxt = sld_pkg::ST_HUNT;
      end
    endcase
  end

endmodule

FILE: src/sld_datapath.sv
// ----------------------------------------------------------------------------
// sld_datapath - deframer datapath
// Holds the sync register, frame length, word count, running sum, the
// payload buffer and the output register.
// ----------------------------------------------------------------------------
module sld_datapath #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sld_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                        cfg_we,
  input  logic [sld_pkg::BYTE_W-1:0]  cfg_wdata,
  input  sld_pkg::sld_cmd_t           cmd,
  output sld_pkg::sld_sts_t           sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sld_pkg::BYTE_W-1:0]  out_payload,
  output logic                        out_last,
  output logic                        out_empty
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [sld_pkg::BYTE_W-1:0] MAX_LEN = sld_pkg::BYTE_W'(MAX_PAYLOAD);

  logic [sld_pkg::BYTE_W-1:0] sync_r;
  logic [sld_pkg::BYTE_W-1:0] frame_length_r;
  logic [sld_pkg::BYTE_W-1:0] bytes_seen_r;
  logic [sld_pkg::BYTE_W-1:0] sum_r;
  logic [sld_pkg::BYTE_W-1:0] seen_inc;
  logic [AW-1:0]              rd_idx_r;
  logic [sld_pkg::BYTE_W-1:0] rd_data_r;
  logic [sld_pkg::BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic                       store_en;
  logic                       out_valid_r;
  logic [sld_pkg::BYTE_W-1:0] out_payload_r;
  logic                       out_last_r;
  logic                       out_empty_r;

  assign seen_inc = bytes_seen_r + 8'd1;
  assign store_en = cmd.add_payload && (bytes_seen_r < MAX_LEN);

  // Status toward the controller
  always_comb begin
    sts.is_sync      = (rx_byte == sync_r);
    sts.len_zero     = (rx_byte == '0);
    sts.payload_done = (seen_inc >= frame_length_r);
    sts.check_ok     = (frame_length_r <= MAX_LEN) && (rx_byte == sum_r);
    sts.frame_empty  = (frame_length_r == '0);
    sts.drain_last   = (sld_pkg::BYTE_W'(rd_idx_r) == (frame_length_r - 8'd1));
    sts.out_free     = !out_valid_r || out_ready;
  end

  // Sync register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= sld_pkg::SYNC_RESET;
    end else if (cfg_we) begin
      sync_r <= cfg_wdata;
    end
  end

  // Frame length, word count and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= '0;
      bytes_seen_r   <= '0;
      sum_r          <= '0;
    end else begin
      if (cmd.start_frame) begin
        sum_r          <= rx_byte;
        bytes_seen_r   <= '0;
        frame_length_r <= '0;
      end
      if (cmd.load_len) begin
        frame_length_r <= rx_byte;
        sum_r          <= sum_r + rx_byte;
        bytes_seen_r   <= '0;
      end
      if (cmd.add_payload) begin
        sum_r        <= sum_r + rx_byte;
        bytes_seen_r <= seen_inc;
      end
      if (cmd.clear_frame) begin
        sum_r        <= '0;
        bytes_seen_r <= '0;
      end
    end
  end

  // Payload buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[bytes_seen_r[AW-1:0]] <= rx_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  // Drain read pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
    end else if (cmd.drain_start) begin
      rd_idx_r <= '0;
    end else if (cmd.out_load_data && !sts.drain_last) begin
      rd_idx_r <= rd_idx_r + 1'b1;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load_data || cmd.out_load_empty) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_data) begin
      out_payload_r <= rd_data_r;
      out_last_r    <= sts.drain_last;
      out_empty_r   <= 1'b0;
    end else if (cmd.out_load_empty) begin
      out_payload_r <= '0;
      out_last_r    <= 1'b1;
      out_empty_r   <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;
  assign out_last    = out_last_r;
  assign out_empty   = out_empty_r;

  // Never overwrite a word the sink has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(out_payload_r) && $stable(out_last_r)))
    else $error("output word overwritten while stalled");

  // An empty-frame marker is always the final word of its frame
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> out_last_r)
    else $error("empty-frame word without last flag");

  // Drain only frames that fit the buffer
  a_drain_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (frame_length_r <= MAX_LEN) && (sld_pkg::BYTE_W'(rd_idx_r) < frame_length_r))
    else $error("buffer read outside the stored frame");

endmodule

FILE: src/sync_length_sum_deframer_unit.sv
// ----------------------------------------------------------------------------
// sync_length_sum_deframer_unit - sync/length/payload/checksum deframer
// Parsing: one received word per cycle in the parse states. After a verified
//   checksum word, each payload word is read from the buffer and then loaded
//   into the output register, the load waiting while the output is stalled;
//   no input is taken while the frame drains.
// Reset: control and counts clear, sync value returns to 0xAA; the payload
//   buffer is not cleared, only words written in the current frame are read.
// ----------------------------------------------------------------------------
module sync_length_sum_deframer_unit #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration: sync value
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,   // [7:0] sync_byte
  // Received words
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  // Payload words of verified frames
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] payload_byte
  output logic       out_tlast,  // last_byte
  output logic       out_tuser   // [0] empty_frame
);

  sld_pkg::sld_cmd_t cmd;
  sld_pkg::sld_sts_t sts;

  assign cfg_ready = 1'b1;

  sld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sld_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .rx_byte     (in_tdata),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_wdata   (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_payload (out_tdata),
    .out_last    (out_tlast),
    .out_empty   (out_tuser)
  );

endmodule
